FILE: hdl/bsd_pkg.sv
`timescale 1ns / 1ps
package bsd_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'd61;
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   localparam logic [24:0] ACC_SENTINEL = 25'd1;
   localparam int HOLD_TWO_BIT   = 12;
   localparam int HOLD_THREE_BIT = 18;
   localparam int HOLD_FOUR_BIT  = 24;

   typedef enum logic [1:0] {
      CLS_TERM,
      CLS_PAD,
      CLS_SEXTET,
      CLS_OTHER
   } char_class_type;

   // One queue entry: up to three results produced by a single character.
   // Bytes go out first-first from data[23:16]; cnt is the result count (1..3).
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  cnt;
      logic        bval;
      logic        eom;
   } group_type;

   // {hit, value}
   function automatic logic [6:0] sextet_of(input logic [7:0] ch);
      logic [7:0] d;
      logic [6:0] r;
      d = 8'd0;
      r = 7'd0;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         d = ch - 8'd65;
         r = {1'b1, d[5:0]};
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         d = ch - 8'd71;
         r = {1'b1, d[5:0]};
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         d = ch + 8'd4;
         r = {1'b1, d[5:0]};
      end else if (ch == 8'd43) begin
         r = {1'b1, 6'd62};
      end else if (ch == 8'd47) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   function automatic char_class_type classify(input logic [7:0] ch);
      logic [6:0] s;
      char_class_type c;
      s = sextet_of(ch);
      if (ch == CHAR_NUL || (ch >= CHAR_TAB && ch <= CHAR_CR) || ch == CHAR_SPACE) begin
         c = CLS_TERM;
      end else if (ch == PAD_CHAR) begin
         c = CLS_PAD;
      end else if (s[6]) begin
         c = CLS_SEXTET;
      end else begin
         c = CLS_OTHER;
      end
      return c;
   endfunction

endpackage

FILE: hdl/bsd_front.sv
`timescale 1ns / 1ps
module bsd_front
   import bsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_char,
   output logic       push,
   output group_type  entry
);

   logic [24:0] acc_ff, acc_in;
   logic        pad_ff, pad_in;
   logic [24:0] shifted;
   logic [6:0]  sx;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= ACC_SENTINEL;
         pad_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         pad_ff <= pad_in;
      end
   end

   assign sx      = sextet_of(in_char);
   assign shifted = {acc_ff[18:0], sx[5:0]};

   always_comb begin
      acc_in = acc_ff;
      pad_in = pad_ff;
      push   = 1'b0;
      entry  = '{data: 24'd0, cnt: 2'd1, bval: 1'b0, eom: 1'b1};
      if (accept) begin
         unique case (classify(in_char))
            CLS_TERM: begin
               push   = !pad_ff;
               acc_in = ACC_SENTINEL;
               pad_in = 1'b0;
            end
            CLS_PAD: begin
               if (!pad_ff) begin
                  push = 1'b1;
                  if (acc_ff[HOLD_THREE_BIT]) begin
                     entry = '{data: {acc_ff[17:2], 8'd0}, cnt: 2'd2, bval: 1'b1, eom: 1'b1};
                  end else if (acc_ff[HOLD_TWO_BIT]) begin
                     entry = '{data: {acc_ff[11:4], 16'd0}, cnt: 2'd1, bval: 1'b1, eom: 1'b1};
                  end
                  acc_in = ACC_SENTINEL;
                  pad_in = 1'b1;
               end
            end
            CLS_SEXTET: begin
               if (!pad_ff) begin
                  if (shifted[HOLD_FOUR_BIT]) begin
                     push   = 1'b1;
                     entry  = '{data: shifted[23:0], cnt: 2'd3, bval: 1'b1, eom: 1'b0};
                     acc_in = ACC_SENTINEL;
                  end else begin
                     acc_in = shifted;
                  end
               end
            end
            CLS_OTHER: begin
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: hdl/bsd_queue.sv
`timescale 1ns / 1ps
module bsd_queue
   import bsd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  group_type wr_data,
   input  logic      rd_en,
   output group_type rd_data,
   output logic      full,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   group_type        mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == DEPTH_CNT);
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hdl/bsd_back.sv
`timescale 1ns / 1ps
module bsd_back
   import bsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  group_type  q_head,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_take,
   output logic [7:0] out_byte,
   output logic       byte_valid,
   output logic       end_of_message,
   output logic       last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bval_ff, eom_ff, last_ff;
   logic       load, is_last;

   assign load    = !q_empty && (!valid_ff || out_take);
   assign is_last = (idx_ff == q_head.cnt - 2'd1);
   assign q_pop   = load && is_last;

   always_comb begin
      case (idx_ff)
         2'd0:    byte_in = q_head.data[23:16];
         2'd1:    byte_in = q_head.data[15:8];
         default: byte_in = q_head.data[7:0];
      endcase
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         bval_ff <= q_head.bval;
         eom_ff  <= q_head.eom && is_last;
         last_ff <= is_last;
      end
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign byte_valid     = bval_ff;
   assign end_of_message = eom_ff;
   assign last           = last_ff;

endmodule

FILE: hdl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// Streaming base64 decoder, standard alphabet, one character per transaction.
// Input side: drive req_in_char with req_push high; the character is taken at
// a clock edge where req_full is low. Output side: while rsp_empty is low the
// oldest decoded result sits on the rsp_ ports; pulse rsp_pop to take it.
// Every fourth alphabet character yields three bytes; '=' flushes one or two
// bytes, or an end marker if under two characters are held, and closes the
// message; NUL or whitespace closes it with an end marker (byte_valid low)
// unless '=' did. rsp_last flags the final result of one character.
// Throughput: one character per cycle in while req_full is low, one result per
// cycle out while rsp_pop takes each; the result stage unrolls a queued group
// one byte per cycle, and QUEUE_DEPTH groups buffer bursts between the two.
// req_full rises only when the group queue is full, which happens while the
// receiver holds off rsp_pop; decoding then stalls with no data lost.
// Reset (synchronous) empties the queue and output stage and restores the
// accumulator to its empty state with no padding pending.
module base64_stream_decoder
   import bsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_message,
   output logic       rsp_last
);

   logic      accept;
   logic      f_push;
   group_type f_entry;
   logic      q_full, q_empty, q_pop;
   group_type q_head;
   logic      out_valid;

   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign rsp_empty = !out_valid;

   bsd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_char (req_in_char),
      .push    (f_push),
      .entry   (f_entry)
   );

   bsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (f_push),
      .wr_data (f_entry),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   bsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .out_valid      (out_valid),
      .out_take       (rsp_pop && !rsp_empty),
      .out_byte       (rsp_out_byte),
      .byte_valid     (rsp_byte_valid),
      .end_of_message (rsp_end_of_message),
      .last           (rsp_last)
   );

`ifndef SYNTHESIS
   a_eom_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_end_of_message |-> rsp_last)
      else $error("end_of_message on a result that is not last");

   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_byte_valid |-> rsp_end_of_message && rsp_out_byte == 8'd0)
      else $error("end marker with bad contents");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("reset did not clear the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("result changed while stalled");
`endif

endmodule
